// File: hdl/kmwj_pkg.sv
package kmwj_pkg;

    localparam int WALL_W = 13;
    localparam int CFG_W  = 7;
    localparam int POS_W  = 14;
    localparam int DIVC_W = 4;

    localparam logic       KIND_START = 1'b0;
    localparam logic       KIND_WALL  = 1'b1;
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_INIT,
        S_WCHK,
        S_DIV,
        S_MUL,
        S_CELL,
        S_FRD,
        S_FCHK,
        S_CRD,
        S_CCHK,
        S_RKA,
        S_RKB,
        S_RKC,
        S_DONE
    } t_state;

endpackage

// File: hdl/kruskal_maze_wall_joiner.sv
// A start item initialises one parent and rank entry per cycle over the W*H cells.
// A wall item in range with joins left runs the 14-step divider to find its two
// cells, walks both finds with path compression on the parent table, and unites
// the roots by rank if they differ; a bad or late wall goes straight to the result.
// A stalled result holds the block in S_DONE. One item at a time.
// Reset: control cleared, joins counter zero, grid 16 x 16; tables undefined until start.
module kruskal_maze_wall_joiner
    import kmwj_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_kind,
    input  logic [WALL_W-1:0] i_wall_index,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [WALL_W-1:0] o_wall_echo,
    output logic              o_wall_opened,
    output logic              o_maze_complete,
    output logic              o_index_bad,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int CW   = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CAP  = MAX_SIDE * MAX_SIDE;
    localparam int RW   = 4;
    localparam int BW   = POS_W + SW;

    t_state r_state, n_state;

    logic [CW-1:0] parent_mem [CAP];
    logic [RW-1:0] rank_mem   [CAP];

    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [SW-1:0]    r_w, r_h;
    logic [2*SW-1:0]  r_cells;
    logic [2*SW:0]    r_wcount;
    logic [CW:0]      r_idx;
    logic [CW-1:0]    r_joins;
    logic             r_kind;
    logic [WALL_W-1:0] r_wall;
    logic [POS_W-1:0] r_dvd, r_quo;
    logic [SW+1:0]    r_rem;
    logic [DIVC_W-1:0] r_cnt;
    logic [BW-1:0]    r_base;
    logic [CW-1:0]    r_c2, r_tgt, r_root, r_node, r_a;
    logic             r_second;
    logic [RW-1:0]    r_ra;
    logic             r_opened, r_bad;
    logic             r_out_valid;
    logic [WALL_W-1:0] r_echo;
    logic             r_complete;

    logic [CW-1:0]    r_pq;
    logic [RW-1:0]    r_rq;

    logic [CW-1:0]    w_paddr, w_pwaddr, w_pwdata;
    logic             w_pwe;
    logic [CW-1:0]    w_raddr, w_rwaddr;
    logic [RW-1:0]    w_rwdata;
    logic             w_rwe;

    logic [SW-1:0]    w_cw, w_ch;
    logic [SW:0]      w_lw;
    logic [SW+1:0]    w_trial;
    logic [BW:0]      w_sum;
    logic [CW-1:0]    w_c1, w_c2;
    logic             w_out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_cw = SW'(1);
        end else if (int'(r_cfg_w) > MAX_SIDE) begin
            w_cw = SW'(MAX_SIDE);
        end else begin
            w_cw = SW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            w_ch = SW'(1);
        end else if (int'(r_cfg_h) > MAX_SIDE) begin
            w_ch = SW'(MAX_SIDE);
        end else begin
            w_ch = SW'(r_cfg_h);
        end
    end

    assign w_lw    = {r_w, 1'b0} - (SW+1)'(1);
    assign w_trial = {r_rem[SW:0], r_dvd[POS_W-1]};

    always_comb begin
        if (r_quo[0]) begin
            w_sum = (BW+1)'(r_base) + (BW+1)'(r_rem);
            w_c1  = CW'(w_sum >> 1);
            w_c2  = w_c1 + CW'(r_w);
        end else begin
            w_sum = (BW+1)'(r_base) + (BW+1)'(r_rem) - (BW+1)'(1);
            w_c1  = CW'(w_sum >> 1);
            w_c2  = CW'((w_sum + (BW+1)'(2)) >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W'(16);
            r_cfg_h <= CFG_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:  r_cfg_w <= i_cfg_data;
                REG_GRID_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        w_paddr  = r_root;
        w_pwe    = 1'b0;
        w_pwaddr = r_node;
        w_pwdata = r_root;
        w_raddr  = r_a;
        w_rwe    = 1'b0;
        w_rwaddr = r_root;
        w_rwdata = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_kind == KIND_START) ? S_START : S_WCHK;
                end
            end
            S_START: n_state = S_INIT;
            S_INIT: begin
                if (r_idx == (CW+1)'(r_cells)) begin
                    n_state = S_DONE;
                end else begin
                    w_pwe    = 1'b1;
                    w_pwaddr = CW'(r_idx);
                    w_pwdata = CW'(r_idx);
                    w_rwe    = 1'b1;
                    w_rwaddr = CW'(r_idx);
                    w_rwdata = '0;
                end
            end
            S_WCHK: begin
                if ((2*SW+1)'(r_wall) >= r_wcount || r_joins == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == DIVC_W'(POS_W - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_CELL;
            S_CELL: n_state = S_FRD;
            S_FRD: begin
                w_paddr = r_root;
                n_state = S_FCHK;
            end
            S_FCHK: n_state = (r_pq == r_root) ? S_CRD : S_FRD;
            S_CRD: begin
                w_paddr = r_node;
                if (r_node == r_root) begin
                    if (!r_second) begin
                        n_state = S_FRD;
                    end else if (r_a == r_root) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RKA;
                    end
                end else begin
                    n_state = S_CCHK;
                end
            end
            S_CCHK: begin
                w_pwe    = 1'b1;
                w_pwaddr = r_node;
                w_pwdata = r_root;
                n_state  = S_CRD;
            end
            S_RKA: begin
                w_raddr = r_a;
                n_state = S_RKB;
            end
            S_RKB: begin
                w_raddr = r_root;
                n_state = S_RKC;
            end
            S_RKC: begin
                w_pwe = 1'b1;
                if (r_ra > r_rq) begin
                    w_pwaddr = r_root;
                    w_pwdata = r_a;
                end else begin
                    w_pwaddr = r_a;
                    w_pwdata = r_root;
                    if (r_ra == r_rq) begin
                        w_rwe    = 1'b1;
                        w_rwaddr = r_root;
                        w_rwdata = r_rq + RW'(1);
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pq <= parent_mem[w_paddr];
        if (w_pwe) begin
            parent_mem[w_pwaddr] <= w_pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rq <= rank_mem[w_raddr];
        if (w_rwe) begin
            rank_mem[w_rwaddr] <= w_rwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= SW'(16);
            r_h     <= SW'(16);
            r_joins <= '0;
        end else begin
            case (r_state)
                S_START: begin
                    r_w <= w_cw;
                    r_h <= w_ch;
                end
                S_INIT: begin
                    if (r_idx == (CW+1)'(r_cells)) begin
                        r_joins <= CW'(r_cells - (2*SW)'(1));
                    end
                end
                S_RKC: r_joins <= r_joins - CW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcount <= (2*SW+1)'(2*16*16 - 32);
        end else if (r_state == S_INIT) begin
            r_wcount <= {r_cells, 1'b0} - (2*SW+1)'(r_w) - (2*SW+1)'(r_h);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kind   <= i_kind;
                r_wall   <= i_wall_index;
                r_opened <= 1'b0;
                r_bad    <= 1'b0;
                r_second <= 1'b0;
                r_idx    <= '0;
                r_cnt    <= '0;
            end
            S_START: r_cells <= (2*SW)'(w_cw) * (2*SW)'(w_ch);
            S_INIT:  r_idx   <= r_idx + (CW+1)'(1);
            S_WCHK: begin
                r_bad <= ((2*SW+1)'(r_wall) >= r_wcount);
                r_dvd <= {r_wall, 1'b1};
                r_rem <= '0;
                r_quo <= '0;
            end
            S_DIV: begin
                r_cnt <= r_cnt + DIVC_W'(1);
                r_dvd <= {r_dvd[POS_W-2:0], 1'b0};
                if (w_trial >= (SW+2)'(w_lw)) begin
                    r_rem <= w_trial - (SW+2)'(w_lw);
                    r_quo <= {r_quo[POS_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[POS_W-2:0], 1'b0};
                end
            end
            S_MUL: begin
                if (r_quo[0]) begin
                    r_base <= BW'(r_quo - POS_W'(1)) * BW'(r_w);
                end else begin
                    r_base <= BW'(r_quo) * BW'(r_w);
                end
            end
            S_CELL: begin
                r_tgt  <= w_c1;
                r_root <= w_c1;
                r_c2   <= w_c2;
            end
            S_FCHK: begin
                if (r_pq == r_root) begin
                    r_node <= r_tgt;
                end else begin
                    r_root <= r_pq;
                end
            end
            S_CRD: begin
                if (r_node == r_root && !r_second) begin
                    r_a      <= r_root;
                    r_second <= 1'b1;
                    r_tgt    <= r_c2;
                    r_root   <= r_c2;
                end
            end
            S_CCHK: r_node <= r_pq;
            S_RKB:  r_ra   <= r_rq;
            S_RKC:  r_opened <= 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_echo     <= (r_kind == KIND_WALL) ? r_wall : '0;
            r_complete <= (r_joins == '0);
        end
    end

    logic r_res_opened, r_res_bad;
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_res_opened <= r_opened && (r_kind == KIND_WALL);
            r_res_bad    <= r_bad && (r_kind == KIND_WALL);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_wall_echo     = r_echo;
    assign o_wall_opened   = r_res_opened;
    assign o_maze_complete = r_complete;
    assign o_index_bad     = r_res_bad;

    a_unite_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RKC |=> r_joins == $past(r_joins) - CW'(1))
        else $error("join count not decremented on union");

    a_open_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_wall_opened |-> !o_index_bad)
        else $error("opened wall flagged bad");

    a_union_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RKA |-> r_a != r_root && r_second)
        else $error("union of equal roots");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_in_stall)
        else $error("input taken while busy");

endmodule

// File: dv/kruskal_maze_wall_joiner_check.sv
module kruskal_maze_wall_joiner_check
    import kmwj_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_kind,
    input  logic [WALL_W-1:0] i_wall_index,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [WALL_W-1:0] i_wall_echo,
    input  logic              i_wall_opened,
    input  logic              i_maze_complete,
    input  logic              i_index_bad,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS_MAX = MAX_SIDE * MAX_SIDE;
    localparam int CELL_W    = $clog2(CELLS_MAX);

    typedef struct packed {
        logic [WALL_W-1:0] echo;
        logic              opened;
        logic              complete;
        logic              bad;
    } t_wall_verdict;

    logic [CELL_W-1:0] parent_of [CELLS_MAX];
    logic [3:0]       rank_of   [CELLS_MAX];
    int               joins_left;
    logic [CFG_W-1:0] reg_width;
    logic [CFG_W-1:0] reg_height;
    int               maze_w;
    int               maze_h;
    t_wall_verdict    verdicts_due [$];

    assign o_pending = verdicts_due.size();

    function automatic int clamp_side(logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return int'(v);
    endfunction

    function automatic int find_root(int c);
        int r;
        int n;
        int nxt;
        r = c;
        while (int'(parent_of[r]) != r) r = int'(parent_of[r]);
        n = c;
        while (n != r) begin
            nxt = int'(parent_of[n]);
            parent_of[n] = CELL_W'(r);
            n = nxt;
        end
        return r;
    endfunction

    function automatic int layout_cell(int pos, int lw);
        return ((pos / lw) * maze_w + (pos % lw)) >> 1;
    endfunction

    function automatic t_wall_verdict judge_item(logic kind, logic [WALL_W-1:0] wall);
        t_wall_verdict v;
        int cells, wcount, lw, pos, p1, p2, a, b;
        v = '0;
        if (kind == KIND_START) begin
            maze_w = clamp_side(reg_width);
            maze_h = clamp_side(reg_height);
            cells = maze_w * maze_h;
            for (int i = 0; i < cells; i++) begin
                parent_of[i] = CELL_W'(i);
                rank_of[i] = '0;
            end
            joins_left = cells - 1;
        end else begin
            wcount = (maze_w - 1) * maze_h + maze_w * (maze_h - 1);
            v.echo = wall;
            if (int'(wall) >= wcount) begin
                v.bad = 1'b1;
            end else if (joins_left != 0) begin
                lw = 2 * maze_w - 1;
                pos = 2 * int'(wall) + 1;
                if (((pos / lw) & 1) != 0) begin
                    p1 = pos - lw;
                    p2 = pos + lw;
                end else begin
                    p1 = pos - 1;
                    p2 = pos + 1;
                end
                a = find_root(layout_cell(p1, lw));
                b = find_root(layout_cell(p2, lw));
                if (a != b) begin
                    if (rank_of[a] < rank_of[b]) begin
                        parent_of[a] = CELL_W'(b);
                    end else if (rank_of[a] > rank_of[b]) begin
                        parent_of[b] = CELL_W'(a);
                    end else begin
                        parent_of[a] = CELL_W'(b);
                        rank_of[b] = rank_of[b] + 4'd1;
                    end
                    joins_left--;
                    v.opened = 1'b1;
                end
            end
        end
        v.complete = (joins_left == 0);
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_wall_verdict want;
        t_wall_verdict got;
        if (!i_rst_n) begin
            joins_left = 0;
            reg_width = 7'd16;
            reg_height = 7'd16;
            maze_w = 16;
            maze_h = 16;
            verdicts_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_wall_echo, i_wall_opened, i_maze_complete, i_index_bad};
                if (verdicts_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: echo=%0d opened=%b complete=%b bad=%b",
                                 got.echo, got.opened, got.complete, got.bad);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = verdicts_due.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: expected echo=%0d opened=%b ",
                                      "complete=%b bad=%b, got echo=%0d opened=%b ",
                                      "complete=%b bad=%b"},
                                     want.echo, want.opened, want.complete, want.bad,
                                     got.echo, got.opened, got.complete, got.bad);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                verdicts_due.push_back(judge_item(i_kind, i_wall_index));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_GRID_WIDTH) reg_width = i_cfg_data;
                else if (i_cfg_index == REG_GRID_HEIGHT) reg_height = i_cfg_data;
            end
        end
    end
endmodule

// File: dv/kruskal_maze_wall_joiner_test.sv
module kruskal_maze_wall_joiner_test;
    import kmwj_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SIDE_MAX    = 64;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              i_kind = KIND_START;
    logic [WALL_W-1:0] i_wall_index = '0;
    logic              i_out_stall = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [1:0]        i_cfg_index = REG_GRID_WIDTH;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [WALL_W-1:0] o_wall_echo;
    logic              o_wall_opened;
    logic              o_maze_complete;
    logic              o_index_bad;
    logic              o_cfg_ready;
    int                fail_count;
    int                pending;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                items_sent = 0;
    int                cycle_count = 0;
    int                maze_w = 16;
    int                maze_h = 16;

    kruskal_maze_wall_joiner #(.MAX_SIDE(SIDE_MAX)) u_top (.*);

    kruskal_maze_wall_joiner_check #(.MAX_SIDE(SIDE_MAX)) u_check (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_kind, .i_wall_index,
        .i_out_valid(o_out_valid), .i_out_stall, .i_wall_echo(o_wall_echo),
        .i_wall_opened(o_wall_opened), .i_maze_complete(o_maze_complete),
        .i_index_bad(o_index_bad), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("kruskal_maze_wall_joiner regression: fail");
            $finish;
        end
    end

    task automatic send_item(logic kind, logic [WALL_W-1:0] wall);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_wall_index <= wall;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        maze_w = (w < 1) ? 1 : (w > SIDE_MAX) ? SIDE_MAX : int'(w);
        maze_h = (h < 1) ? 1 : (h > SIDE_MAX) ? SIDE_MAX : int'(h);
    endtask

    task automatic run_maze(int max_walls, bit hold_off);
        int wcount;
        int walls [$];
        int j;
        int tmp;
        wcount = (maze_w - 1) * maze_h + maze_w * (maze_h - 1);
        send_item(KIND_START, WALL_W'($urandom));
        for (int i = 0; i < wcount; i++) walls.push_back(i);
        for (int i = wcount - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = walls[i];
            walls[i] = walls[j];
            walls[j] = tmp;
        end
        if ($urandom_range(9) == 0) max_walls = $urandom_range(max_walls);
        for (int i = 0; i < wcount && i < max_walls; i++) begin
            if (hold_off && i == wcount / 2) drain();
            if ($urandom_range(19) == 0)
                send_item(KIND_WALL, WALL_W'($urandom));
            if ($urandom_range(49) == 0)
                send_item(KIND_WALL, WALL_W'(wcount + $urandom_range(3)));
            send_item(KIND_WALL, WALL_W'(walls[i]));
        end
    endtask

    initial begin
        int phase_goal;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(KIND_WALL, 13'd0);
        send_item(KIND_WALL, 13'h1FFF);
        set_grid(7'd1, 7'd1);
        send_item(KIND_START, 13'h1FFF);
        send_item(KIND_WALL, 13'd0);
        write_reg(REG_SPARE_A, 7'h7F);
        write_reg(REG_SPARE_B, 7'h00);
        send_item(KIND_START, 13'd0);
        send_item(KIND_WALL, 13'd0);
        set_grid(7'd127, 7'd0);
        send_item(KIND_START, 13'd0);
        send_item(KIND_WALL, 13'd0);
        send_item(KIND_WALL, 13'd62);
        send_item(KIND_WALL, 13'd63);
        set_grid(7'd64, 7'd64);
        send_item(KIND_START, 13'd0);
        send_item(KIND_WALL, 13'd8063);
        send_item(KIND_WALL, 13'd8064);
        send_item(KIND_WALL, 13'd4095);
        send_item(KIND_WALL, 13'd4096);
        send_item(KIND_WALL, 13'd0);
        send_item(KIND_WALL, 13'd8063);
        set_grid(7'd2, 7'd2);
        write_reg(REG_GRID_WIDTH, 7'd5);
        send_item(KIND_START, 13'd0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 74; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 74; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            phase_goal = items_sent + 350;
            while (items_sent < phase_goal) begin
                if ($urandom_range(29) == 0)
                    set_grid(7'($urandom), 7'($urandom));
                else if ($urandom_range(3) != 0)
                    set_grid(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)));
                if (maze_w * maze_h > 256)
                    run_maze(40, 1'b0);
                else
                    run_maze(1000, phase == 2 && items_sent + 60 > phase_goal);
                if ($urandom_range(3) == 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("kruskal_maze_wall_joiner regression: pass");
        else
            $display("kruskal_maze_wall_joiner regression: fail");
        $finish;
    end
endmodule
